// ----- rtl/core/sien_pkg.sv -----
package sien_pkg;

  // Field widths
  localparam int VW = 24;              // signed field values
  localparam int RW = 23;              // radius register
  localparam int MW = 32;              // shared multiplier operand width

  localparam logic [1:0] MODE_VERTEX = 2'd0;
  localparam logic [1:0] MODE_COMP   = 2'd1;
  localparam logic [1:0] MODE_CLOSE  = 2'd2;

  // Multiplier operand selection
  typedef enum logic [3:0] {
    MS_M0, MS_M1, MS_M2, MS_M3, MS_R, MS_EH, MS_EL, MS_AH, MS_AL
  } mul_sel_t;

  // What the datapath does with the registered product
  typedef enum logic [3:0] {
    AC_NONE, AC_DSET, AC_DADD, AC_RCMP, AC_ERR, AC_ANA, AC_HI, AC_W, AC_SUME, AC_SUMA
  } acc_op_t;

  typedef enum logic [1:0] {SQ_MAXE, SQ_ERRS, SQ_MAXA, SQ_ANAS} sq_sel_t;

  typedef enum logic [2:0] {CP_NONE, CP_ME, CP_LE, CP_DEN, CP_RM, CP_RL} cap_t;

  typedef enum logic [1:0] {ST_OK = 2'd0, ST_NOCELL = 2'd1, ST_ANAZERO = 2'd2} status_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     close_upd;
    logic     clr_cell;
    logic     clr_stream;
    logic     sq_start;
    sq_sel_t  sq_sel;
    logic     div_start;
    logic     div_le;
    cap_t     cap;
    logic     out_load;
    status_t  out_code;
  } cmd_t;

  typedef struct packed {
    logic all_inside;
    logic last;
    logic count_zero;
    logic ana_zero;
    logic sq_done;
    logic div_done;
  } stat_t;

endpackage

// ----- rtl/core/sien_ifs.sv -----
// Input beat: one vertex, field component or cell close.
interface sien_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic signed [23:0] coord_x;
  logic signed [23:0] coord_y;
  logic signed [23:0] coord_z;
  logic signed [23:0] num_re;
  logic signed [23:0] num_im;
  logic signed [23:0] ana_re;
  logic signed [23:0] ana_im;
  logic [23:0] cell_volume;
  logic        last_cell;
  modport source (output valid, mode, coord_x, coord_y, coord_z, num_re, num_im,
                  ana_re, ana_im, cell_volume, last_cell, input ready);
  modport sink (input valid, mode, coord_x, coord_y, coord_z, num_re, num_im,
                ana_re, ana_im, cell_volume, last_cell, output ready);
endinterface

// Result beat: the norms of one stream.
interface sien_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cells_compared;
  logic [31:0] max_err;
  logic [31:0] rel_max_err;
  logic [31:0] l2_err;
  logic [31:0] rel_l2_err;
  logic [1:0]  status;
  modport source (output valid, cells_compared, max_err, rel_max_err, l2_err,
                  rel_l2_err, status, input ready);
  modport sink (input valid, cells_compared, max_err, rel_max_err, l2_err,
                rel_l2_err, status, output ready);
endinterface

// ----- rtl/core/sien_sqrt.sv -----
// Floor square root of a 64-bit value, one result bit per cycle.
module sien_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] x_r, x_nxt;
  logic [63:0] res_r, res_nxt;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] bit_v;
  logic [63:0] trial;

  // One digit step of the restoring root
  always_comb begin
    bit_v   = 64'd1 << {cnt_r, 1'b0};
    trial   = res_r + bit_v;
    x_nxt   = x_r;
    res_nxt = res_r >> 1;
    if (x_r >= trial) begin
      x_nxt   = x_r - trial;
      res_nxt = (res_r >> 1) + bit_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        x_r    <= x;
        res_r  <= '0;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        x_r   <= x_nxt;
        res_r <= res_nxt;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("root done without a running pass");
endmodule

// ----- rtl/core/sien_div.sv -----
// Saturating quotient floor(num * 2^16 / den), one quotient bit per cycle.
module sien_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);
  logic [47:0] n_r;
  logic [47:0] q_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] shifted;
  logic [32:0] diff;

  // Restoring step
  always_comb begin
    shifted = {rem_r, n_r[47]};
    diff    = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        n_r    <= {num, 16'd0};
        q_r    <= '0;
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= 6'd47;
      end else if (busy_r) begin
        n_r <= {n_r[46:0], 1'b0};
        if (!diff[32]) begin
          rem_r <= diff[31:0];
          q_r   <= {q_r[46:0], 1'b1};
        end else begin
          rem_r <= shifted[31:0];
          q_r   <= {q_r[46:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = (q_r[47:32] != 16'd0) ? 32'hFFFF_FFFF : q_r[31:0];
endmodule

// ----- rtl/core/sien_datapath.sv -----
// Arithmetic, stream state and result register of the error-norm unit.
module sien_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sien_pkg::cmd_t       cmd,
  output sien_pkg::stat_t      stat,
  input  logic                 cfg_we,
  input  logic [22:0]          cfg_wdata,
  input  logic [1:0]           in_mode,
  input  logic signed [23:0]   in_coord_x,
  input  logic signed [23:0]   in_coord_y,
  input  logic signed [23:0]   in_coord_z,
  input  logic signed [23:0]   in_num_re,
  input  logic signed [23:0]   in_num_im,
  input  logic signed [23:0]   in_ana_re,
  input  logic signed [23:0]   in_ana_im,
  input  logic [23:0]          in_cell_volume,
  input  logic                 in_last_cell,
  output logic [31:0]          out_cells_compared,
  output logic [31:0]          out_max_err,
  output logic [31:0]          out_rel_max_err,
  output logic [31:0]          out_l2_err,
  output logic [31:0]          out_rel_l2_err,
  output logic [1:0]           out_status
);
  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? MAX64 : s[63:0];
  endfunction

  function automatic logic [24:0] mag(input logic signed [24:0] v);
    return v[24] ? 25'(-v) : 25'(v);
  endfunction

  logic [22:0] radius_r;
  logic [24:0] m_r [4];
  logic [23:0] vol_r;
  logic        last_r;
  logic [63:0] prod_r;
  logic [48:0] d_r;
  logic [63:0] hi_r, w_r;
  logic        all_inside_r;
  logic [63:0] cell_err_r, cell_ana_r, max_err_r, max_ana_r, err_sum_r, ana_sum_r;
  logic [31:0] count_r;
  logic [31:0] me_r, le_r, den_r, rm_r, rl_r;
  logic [31:0] mul_a, mul_b;
  logic [63:0] sq_x;
  logic        sq_done, div_done;
  logic [31:0] sq_root, div_quot;
  logic [63:0] w_nxt;

  // Radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 23'd65536;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // Beat capture: magnitudes are taken here so the multiplier sees them directly
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vol_r  <= in_cell_volume;
      last_r <= in_last_cell;
      if (in_mode == sien_pkg::MODE_VERTEX) begin
        m_r[0] <= mag(25'(in_coord_x));
        m_r[1] <= mag(25'(in_coord_y));
        m_r[2] <= mag(25'(in_coord_z));
        m_r[3] <= '0;
      end else begin
        m_r[0] <= mag(25'(in_num_re) - 25'(in_ana_re));
        m_r[1] <= mag(25'(in_num_im) - 25'(in_ana_im));
        m_r[2] <= mag(25'(in_ana_re));
        m_r[3] <= mag(25'(in_ana_im));
      end
    end
  end

  // Shared multiplier with registered product
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      sien_pkg::MS_M0: begin mul_a = 32'(m_r[0]); mul_b = 32'(m_r[0]); end
      sien_pkg::MS_M1: begin mul_a = 32'(m_r[1]); mul_b = 32'(m_r[1]); end
      sien_pkg::MS_M2: begin mul_a = 32'(m_r[2]); mul_b = 32'(m_r[2]); end
      sien_pkg::MS_M3: begin mul_a = 32'(m_r[3]); mul_b = 32'(m_r[3]); end
      sien_pkg::MS_R:  begin mul_a = 32'(radius_r); mul_b = 32'(radius_r); end
      sien_pkg::MS_EH: begin mul_a = 32'(vol_r); mul_b = cell_err_r[63:32]; end
      sien_pkg::MS_EL: begin mul_a = 32'(vol_r); mul_b = cell_err_r[31:0]; end
      sien_pkg::MS_AH: begin mul_a = 32'(vol_r); mul_b = cell_ana_r[63:32]; end
      sien_pkg::MS_AL: begin mul_a = 32'(vol_r); mul_b = cell_ana_r[31:0]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  // Weighted term from the high and low partial products
  assign w_nxt = (hi_r[63:48] != 16'd0) ? MAX64
                 : sat_add({hi_r[47:0], 16'd0}, {16'd0, prod_r[63:16]});

  // Stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_inside_r <= 1'b1;
      cell_err_r   <= '0;
      cell_ana_r   <= '0;
      max_err_r    <= '0;
      max_ana_r    <= '0;
      err_sum_r    <= '0;
      ana_sum_r    <= '0;
      count_r      <= '0;
    end else begin
      case (cmd.acc_op)
        sien_pkg::AC_DSET: d_r <= prod_r[48:0];
        sien_pkg::AC_DADD: d_r <= d_r + prod_r[48:0];
        sien_pkg::AC_RCMP: if (64'(d_r) > prod_r) all_inside_r <= 1'b0;
        sien_pkg::AC_ERR:  cell_err_r <= sat_add(cell_err_r, prod_r);
        sien_pkg::AC_ANA:  cell_ana_r <= sat_add(cell_ana_r, prod_r);
        sien_pkg::AC_HI:   hi_r <= prod_r;
        sien_pkg::AC_W:    w_r <= w_nxt;
        sien_pkg::AC_SUME: err_sum_r <= sat_add(err_sum_r, w_r);
        sien_pkg::AC_SUMA: ana_sum_r <= sat_add(ana_sum_r, w_r);
        default: ;
      endcase
      if (cmd.close_upd) begin
        if (cell_err_r > max_err_r) max_err_r <= cell_err_r;
        if (cell_ana_r > max_ana_r) max_ana_r <= cell_ana_r;
        if (count_r != 32'hFFFF_FFFF) count_r <= count_r + 32'd1;
      end
      if (cmd.clr_cell || cmd.clr_stream) begin
        all_inside_r <= 1'b1;
        cell_err_r   <= '0;
        cell_ana_r   <= '0;
      end
      if (cmd.clr_stream) begin
        max_err_r <= '0;
        max_ana_r <= '0;
        err_sum_r <= '0;
        ana_sum_r <= '0;
        count_r   <= '0;
      end
    end
  end

  // Root and quotient units
  always_comb begin
    case (cmd.sq_sel)
      sien_pkg::SQ_MAXE: sq_x = max_err_r;
      sien_pkg::SQ_ERRS: sq_x = err_sum_r;
      sien_pkg::SQ_MAXA: sq_x = max_ana_r;
      sien_pkg::SQ_ANAS: sq_x = ana_sum_r;
      default:           sq_x = max_err_r;
    endcase
  end

  sien_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  sien_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cmd.div_le ? le_r : me_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    case (cmd.cap)
      sien_pkg::CP_ME:  me_r  <= sq_root;
      sien_pkg::CP_LE:  le_r  <= sq_root;
      sien_pkg::CP_DEN: den_r <= sq_root;
      sien_pkg::CP_RM:  rm_r  <= div_quot;
      sien_pkg::CP_RL:  rl_r  <= div_quot;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= 2'(cmd.out_code);
      if (cmd.out_code == sien_pkg::ST_NOCELL) begin
        out_cells_compared <= '0;
        out_max_err        <= '0;
        out_l2_err         <= '0;
      end else begin
        out_cells_compared <= count_r;
        out_max_err        <= me_r;
        out_l2_err         <= le_r;
      end
      if (cmd.out_code == sien_pkg::ST_OK) begin
        out_rel_max_err <= rm_r;
        out_rel_l2_err  <= rl_r;
      end else begin
        out_rel_max_err <= '0;
        out_rel_l2_err  <= '0;
      end
    end
  end

  assign stat.all_inside = all_inside_r;
  assign stat.last       = last_r;
  assign stat.count_zero = (count_r == 32'd0);
  assign stat.ana_zero   = (max_ana_r == 64'd0) || (ana_sum_r == 64'd0);
  assign stat.sq_done    = sq_done;
  assign stat.div_done   = div_done;

  a_clear_stream: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_stream |=> (count_r == 32'd0) && all_inside_r) else
    $error("stream state not cleared after a result");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.close_upd && !cmd.clr_stream && count_r != 32'hFFFF_FFFF)
      |=> count_r == $past(count_r) + 32'd1) else $error("cell count did not step");
endmodule

// ----- rtl/core/sien_ctrl.sv -----
// Sequencer of the error-norm unit: one beat at a time, then the final norms.
module sien_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_mode,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sien_pkg::stat_t  stat,
  output sien_pkg::cmd_t   cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_VX, S_VY, S_VZ, S_VR, S_VC,
    S_C0, S_C1, S_C2, S_C3, S_C4,
    S_K0, S_K1, S_K2, S_K3, S_K4, S_K5, S_K6, S_KEND,
    S_FSTART, S_FW1, S_FW2, S_FW3, S_FD1, S_FW4, S_FW5, S_FD2, S_FW6, S_FOUT
  } state_t;

  state_t             state_r, state_nxt;
  sien_pkg::status_t  code_r, code_nxt;
  logic               out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mul_sel   = sien_pkg::MS_M0;
    cmd.acc_op    = sien_pkg::AC_NONE;
    cmd.sq_sel    = sien_pkg::SQ_MAXE;
    cmd.cap       = sien_pkg::CP_NONE;
    cmd.out_code  = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_mode)
            sien_pkg::MODE_VERTEX: state_nxt = S_VX;
            sien_pkg::MODE_COMP:   state_nxt = S_C0;
            sien_pkg::MODE_CLOSE:  state_nxt = S_K0;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end
      // Corner: x^2, y^2, z^2 summed, then compared with r^2
      S_VX: begin cmd.mul_sel = sien_pkg::MS_M0; state_nxt = S_VY; end
      S_VY: begin
        cmd.mul_sel = sien_pkg::MS_M1; cmd.acc_op = sien_pkg::AC_DSET; state_nxt = S_VZ;
      end
      S_VZ: begin
        cmd.mul_sel = sien_pkg::MS_M2; cmd.acc_op = sien_pkg::AC_DADD; state_nxt = S_VR;
      end
      S_VR: begin
        cmd.mul_sel = sien_pkg::MS_R; cmd.acc_op = sien_pkg::AC_DADD; state_nxt = S_VC;
      end
      S_VC: begin cmd.acc_op = sien_pkg::AC_RCMP; state_nxt = S_IDLE; end
      // Component: two error squares, two analytical squares
      S_C0: begin cmd.mul_sel = sien_pkg::MS_M0; state_nxt = S_C1; end
      S_C1: begin
        cmd.mul_sel = sien_pkg::MS_M1; cmd.acc_op = sien_pkg::AC_ERR; state_nxt = S_C2;
      end
      S_C2: begin
        cmd.mul_sel = sien_pkg::MS_M2; cmd.acc_op = sien_pkg::AC_ERR; state_nxt = S_C3;
      end
      S_C3: begin
        cmd.mul_sel = sien_pkg::MS_M3; cmd.acc_op = sien_pkg::AC_ANA; state_nxt = S_C4;
      end
      S_C4: begin cmd.acc_op = sien_pkg::AC_ANA; state_nxt = S_IDLE; end
      // Close: volume-weighted sums from two partial products each
      S_K0: begin
        if (stat.all_inside) begin
          cmd.mul_sel = sien_pkg::MS_EH; state_nxt = S_K1;
        end else begin
          state_nxt = S_KEND;
        end
      end
      S_K1: begin
        cmd.mul_sel = sien_pkg::MS_EL; cmd.acc_op = sien_pkg::AC_HI; state_nxt = S_K2;
      end
      S_K2: begin cmd.acc_op = sien_pkg::AC_W; state_nxt = S_K3; end
      S_K3: begin
        cmd.mul_sel = sien_pkg::MS_AH; cmd.acc_op = sien_pkg::AC_SUME; state_nxt = S_K4;
      end
      S_K4: begin
        cmd.mul_sel = sien_pkg::MS_AL; cmd.acc_op = sien_pkg::AC_HI; state_nxt = S_K5;
      end
      S_K5: begin cmd.acc_op = sien_pkg::AC_W; state_nxt = S_K6; end
      S_K6: begin
        cmd.acc_op = sien_pkg::AC_SUMA; cmd.close_upd = 1'b1; state_nxt = S_KEND;
      end
      S_KEND: begin
        cmd.clr_cell = 1'b1;
        state_nxt    = stat.last ? S_FSTART : S_IDLE;
      end
      // Final norms
      S_FSTART: begin
        if (stat.count_zero) begin
          code_nxt  = sien_pkg::ST_NOCELL;
          state_nxt = S_FOUT;
        end else begin
          cmd.sq_start = 1'b1; cmd.sq_sel = sien_pkg::SQ_MAXE; state_nxt = S_FW1;
        end
      end
      S_FW1: begin
        if (stat.sq_done) begin
          cmd.cap = sien_pkg::CP_ME; cmd.sq_start = 1'b1;
          cmd.sq_sel = sien_pkg::SQ_ERRS; state_nxt = S_FW2;
        end
      end
      S_FW2: begin
        if (stat.sq_done) begin
          cmd.cap = sien_pkg::CP_LE;
          if (stat.ana_zero) begin
            code_nxt  = sien_pkg::ST_ANAZERO;
            state_nxt = S_FOUT;
          end else begin
            cmd.sq_start = 1'b1; cmd.sq_sel = sien_pkg::SQ_MAXA; state_nxt = S_FW3;
          end
        end
      end
      S_FW3: begin
        if (stat.sq_done) begin cmd.cap = sien_pkg::CP_DEN; state_nxt = S_FD1; end
      end
      S_FD1: begin cmd.div_start = 1'b1; cmd.div_le = 1'b0; state_nxt = S_FW4; end
      S_FW4: begin
        if (stat.div_done) begin
          cmd.cap = sien_pkg::CP_RM; cmd.sq_start = 1'b1;
          cmd.sq_sel = sien_pkg::SQ_ANAS; state_nxt = S_FW5;
        end
      end
      S_FW5: begin
        if (stat.sq_done) begin cmd.cap = sien_pkg::CP_DEN; state_nxt = S_FD2; end
      end
      S_FD2: begin cmd.div_start = 1'b1; cmd.div_le = 1'b1; state_nxt = S_FW6; end
      S_FW6: begin
        if (stat.div_done) begin
          cmd.cap = sien_pkg::CP_RL; code_nxt = sien_pkg::ST_OK; state_nxt = S_FOUT;
        end
      end
      // Load the result register once the previous beat has left
      S_FOUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load   = 1'b1;
          cmd.clr_stream = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= sien_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r) else $error("loaded result not offered");
  a_close_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode == sien_pkg::MODE_CLOSE) |=> state_r == S_K0) else
    $error("close beat did not start the close sequence");
  a_sq_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.sq_done |-> (state_r == S_FW1 || state_r == S_FW2 || state_r == S_FW3 ||
                      state_r == S_FW5)) else $error("root finished outside a wait state");
endmodule

// ----- rtl/core/sphere_interior_error_norms_unit.sv -----
// Sphere-interior error norms over a stream of mesh cells.
// Input channel in_ch (valid/ready): a beat is a vertex (mode 0), a field component
// (mode 1) or a cell close with its volume (mode 2); mode 3 beats are dropped.
// A close beat with last_cell set ends the stream and produces one result beat on
// out_ch; all stream state then returns to its reset value, the radius is kept.
// The user must write the radius through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this. Beats pass one at a time through
// the shared 32x32 multiplier; no new beat is taken before the current one is done.
// A close of a cell outside the sphere skips the weighted sums and is not counted.
// The final close computes the norms with the bit-serial square root (32 steps)
// and the bit-serial divider (48 steps); with no counted cell this is skipped, and
// with a zero analytical norm the analytical roots and both divisions are skipped.
// The result waits in an output register; if the receiver stalls, earlier cells of
// the next stream are still taken and only the next final close waits for the slot.
// Reset (rst_n, synchronous, active low) clears the stream, drops any pending
// result and sets the radius to 1.0.
module sphere_interior_error_norms_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [22:0] cfg_wdata,
  sien_in_if.sink     in_ch,
  sien_out_if.source  out_ch
);
  sien_pkg::cmd_t  cmd;
  sien_pkg::stat_t stat;

  sien_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sien_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_mode            (in_ch.mode),
    .in_coord_x         (in_ch.coord_x),
    .in_coord_y         (in_ch.coord_y),
    .in_coord_z         (in_ch.coord_z),
    .in_num_re          (in_ch.num_re),
    .in_num_im          (in_ch.num_im),
    .in_ana_re          (in_ch.ana_re),
    .in_ana_im          (in_ch.ana_im),
    .in_cell_volume     (in_ch.cell_volume),
    .in_last_cell       (in_ch.last_cell),
    .out_cells_compared (out_ch.cells_compared),
    .out_max_err        (out_ch.max_err),
    .out_rel_max_err    (out_ch.rel_max_err),
    .out_l2_err         (out_ch.l2_err),
    .out_rel_l2_err     (out_ch.rel_l2_err),
    .out_status         (out_ch.status)
  );
endmodule
